// ===== rtl/core/bmh_pkg.sv =====
// ---------------------------------------------------------------------------
// bmh_pkg
// Shared types, sizes and codes for the binary min-heap priority queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmh_pkg;

  localparam int CAPACITY    = 256;
  localparam int KEY_BITS    = 32;
  localparam int HANDLE_BITS = 16;

  // heap position, entry count, child index (one bit more than a position)
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int POS_W  = ADDR_W + 1;

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [KEY_BITS-1:0]    key_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CMP,
    ST_UP_PUT,
    ST_EX_LOAD,
    ST_DN_CMP
  } state_t;

  typedef struct packed {
    op_t     op;
    key_t    key;
    handle_t handle;
  } in_item_t;

  typedef struct packed {
    status_t status;
    key_t    min_key;
    handle_t min_handle;
    cnt_t    count;
  } out_item_t;

  typedef struct packed {
    key_t    key;
    handle_t handle;
  } entry_t;

  // one write port, two read ports
  typedef struct packed {
    logic   we;
    addr_t  wr_addr;
    entry_t wr_data;
    addr_t  rd_addr_a;
    addr_t  rd_addr_b;
  } mem_req_t;

  // verdict of the key comparator
  typedef struct packed {
    logic move;
    logic pick_b;
  } cmp_res_t;

endpackage

// ===== rtl/core/bmh_store.sv =====
// ---------------------------------------------------------------------------
// bmh_store
// Heap entry memory: one write port, two registered read ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmh_store (
  input  logic              clk,
  input  bmh_pkg::mem_req_t req,
  output bmh_pkg::entry_t   rd_data_a,
  output bmh_pkg::entry_t   rd_data_b
);

  bmh_pkg::entry_t mem [bmh_pkg::CAPACITY];
  bmh_pkg::entry_t rd_a_r;
  bmh_pkg::entry_t rd_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_r <= mem[req.rd_addr_a];
    rd_b_r <= mem[req.rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ===== rtl/core/bmh_cmp.sv =====
// ---------------------------------------------------------------------------
// bmh_cmp
// Shared key comparator used by both sift-up and sift-down steps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmh_cmp (
  input  logic                down,
  input  bmh_pkg::key_t       mov_key,
  input  bmh_pkg::key_t       key_a,
  input  logic                valid_a,
  input  bmh_pkg::key_t       key_b,
  input  logic                valid_b,
  output bmh_pkg::cmp_res_t   res
);

  logic          a_win;
  logic          b_win;
  bmh_pkg::key_t best_key;

  always_comb begin
    // sift-down: strictly smaller child wins, left kept on ties
    a_win    = valid_a && (key_a < mov_key);
    best_key = a_win ? key_a : mov_key;
    b_win    = valid_b && (key_b < best_key);
    if (down) begin
      res.move   = a_win || b_win;
      res.pick_b = b_win;
    end else begin
      // sift-up: parent on port a moves down only if strictly greater
      res.move   = key_a > mov_key;
      res.pick_b = 1'b0;
    end
  end

endmodule

// ===== rtl/core/bmh_ctrl.sv =====
// ---------------------------------------------------------------------------
// bmh_ctrl
// Sequencer for insert (sift-up) and extract (sift-down) transactions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bmh_pkg::in_item_t   in_item,
  output logic                busy,
  output logic                out_valid,
  output bmh_pkg::out_item_t  out_item,
  output bmh_pkg::mem_req_t   mem_req,
  input  bmh_pkg::entry_t     rd_data_a,
  input  bmh_pkg::entry_t     rd_data_b
);

  bmh_pkg::state_t    state_r, state_nxt;
  bmh_pkg::addr_t     pos_r, pos_nxt;
  bmh_pkg::cnt_t      cnt_r, cnt_nxt;
  bmh_pkg::entry_t    mov_r, mov_nxt;
  bmh_pkg::entry_t    min_r, min_nxt;
  logic               out_valid_r, out_valid_nxt;
  bmh_pkg::out_item_t out_item_r, out_item_nxt;

  bmh_pkg::pos_t      child_l, child_r;
  bmh_pkg::addr_t     parent, grand, best;
  bmh_pkg::cmp_res_t  cmp_res;
  logic               accept;
  logic               is_full, is_empty;

  assign accept   = start && (state_r == bmh_pkg::ST_IDLE);
  assign is_full  = cnt_r == bmh_pkg::CNT_W'(bmh_pkg::CAPACITY);
  assign is_empty = cnt_r == '0;
  assign child_l  = {pos_r, 1'b1};
  assign child_r  = child_l + bmh_pkg::POS_W'(1);
  assign parent   = (pos_r - bmh_pkg::ADDR_W'(1)) >> 1;
  assign grand    = (parent - bmh_pkg::ADDR_W'(1)) >> 1;
  assign best     = cmp_res.pick_b ? child_r[bmh_pkg::ADDR_W-1:0]
                                   : child_l[bmh_pkg::ADDR_W-1:0];

  bmh_cmp u_cmp (
    .down    (state_r == bmh_pkg::ST_DN_CMP),
    .mov_key (mov_r.key),
    .key_a   (rd_data_a.key),
    .valid_a (child_l < bmh_pkg::POS_W'(cnt_r)),
    .key_b   (rd_data_b.key),
    .valid_b (child_r < bmh_pkg::POS_W'(cnt_r)),
    .res     (cmp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmh_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    mov_r      <= mov_nxt;
    min_r      <= min_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    mov_nxt       = mov_r;
    min_nxt       = min_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_req       = '0;

    case (state_r)
      bmh_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_item.op == bmh_pkg::OP_INSERT) begin
            if (is_full) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{bmh_pkg::STATUS_FULL, '0, '0, cnt_r};
            end else begin
              mov_nxt = '{in_item.key, in_item.handle};
              cnt_nxt = cnt_r + bmh_pkg::CNT_W'(1);
              pos_nxt = bmh_pkg::ADDR_W'(cnt_r);
              if (is_empty) begin
                state_nxt = bmh_pkg::ST_UP_PUT;
              end else begin
                mem_req.rd_addr_a = bmh_pkg::ADDR_W'((cnt_r - bmh_pkg::CNT_W'(1)) >> 1);
                state_nxt         = bmh_pkg::ST_UP_CMP;
              end
            end
          end else begin
            if (is_empty) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{bmh_pkg::STATUS_EMPTY, '0, '0, cnt_r};
            end else begin
              // fetch root and last entry together
              mem_req.rd_addr_a = '0;
              mem_req.rd_addr_b = bmh_pkg::ADDR_W'(cnt_r - bmh_pkg::CNT_W'(1));
              state_nxt         = bmh_pkg::ST_EX_LOAD;
            end
          end
        end
      end

      bmh_pkg::ST_UP_CMP: begin
        // port a holds the parent of the hole at pos_r
        if (cmp_res.move) begin
          mem_req.we      = 1'b1;
          mem_req.wr_addr = pos_r;
          mem_req.wr_data = rd_data_a;
          pos_nxt         = parent;
          if (parent == '0) begin
            state_nxt = bmh_pkg::ST_UP_PUT;
          end else begin
            mem_req.rd_addr_a = grand;
          end
        end else begin
          mem_req.we      = 1'b1;
          mem_req.wr_addr = pos_r;
          mem_req.wr_data = mov_r;
          out_valid_nxt   = 1'b1;
          out_item_nxt    = '{bmh_pkg::STATUS_OK, '0, '0, cnt_r};
          state_nxt       = bmh_pkg::ST_IDLE;
        end
      end

      bmh_pkg::ST_UP_PUT: begin
        mem_req.we      = 1'b1;
        mem_req.wr_addr = pos_r;
        mem_req.wr_data = mov_r;
        out_valid_nxt   = 1'b1;
        out_item_nxt    = '{bmh_pkg::STATUS_OK, '0, '0, cnt_r};
        state_nxt       = bmh_pkg::ST_IDLE;
      end

      bmh_pkg::ST_EX_LOAD: begin
        min_nxt = rd_data_a;
        mov_nxt = rd_data_b;
        cnt_nxt = cnt_r - bmh_pkg::CNT_W'(1);
        pos_nxt = '0;
        if (cnt_r == bmh_pkg::CNT_W'(1)) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{bmh_pkg::STATUS_OK, rd_data_a.key, rd_data_a.handle, cnt_nxt};
          state_nxt     = bmh_pkg::ST_IDLE;
        end else begin
          mem_req.rd_addr_a = bmh_pkg::ADDR_W'(1);
          mem_req.rd_addr_b = bmh_pkg::ADDR_W'(2);
          state_nxt         = bmh_pkg::ST_DN_CMP;
        end
      end

      bmh_pkg::ST_DN_CMP: begin
        // ports hold the children of the hole at pos_r
        mem_req.we      = 1'b1;
        mem_req.wr_addr = pos_r;
        if (cmp_res.move) begin
          mem_req.wr_data   = cmp_res.pick_b ? rd_data_b : rd_data_a;
          pos_nxt           = best;
          mem_req.rd_addr_a = bmh_pkg::ADDR_W'({best, 1'b1});
          mem_req.rd_addr_b = bmh_pkg::ADDR_W'({best, 1'b1} + bmh_pkg::POS_W'(1));
        end else begin
          mem_req.wr_data = mov_r;
          out_valid_nxt   = 1'b1;
          out_item_nxt    = '{bmh_pkg::STATUS_OK, min_r.key, min_r.handle, cnt_r};
          state_nxt       = bmh_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bmh_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = state_r != bmh_pkg::ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // entry count stays within capacity
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bmh_pkg::CNT_W'(bmh_pkg::CAPACITY))
    else $error("entry count above capacity");

  // every heap write lands inside the live region
  a_wr_live: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (bmh_pkg::POS_W'(mem_req.wr_addr) < bmh_pkg::POS_W'(cnt_r)))
    else $error("heap write outside live entries");

  // sift-up compare never runs at the root
  a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmh_pkg::ST_UP_CMP) |-> (pos_r != '0))
    else $error("sift-up compare at root");

  // flagged transactions carry zero entry and leave the count alone
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.status != bmh_pkg::STATUS_OK)
      |-> (out_item_r.min_key == '0) && (out_item_r.min_handle == '0)
          && (out_item_r.count == cnt_r))
    else $error("flagged result not clean");

  // a result strobe is a single-cycle pulse per transaction
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && busy |=> !out_valid_r)
    else $error("result strobe repeated");

endmodule

// ===== rtl/core/binary_min_heap_queue.sv =====
// ---------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap priority queue of (key, handle) entries, fixed capacity.
// ---------------------------------------------------------------------------
// Usage: drive in_item and raise start; the transaction is taken at a rising
// edge where start is high and busy is low. op insert adds (key, handle),
// op extract removes the entry with the smallest key (earliest-placed rules
// follow the heap order, equal keys are never passed).
// Each transaction gives one result: out_valid is high for exactly one cycle
// with out_item (status, extracted key/handle or zero, count after the
// transaction). The receiver cannot stall; the result must be taken then.
// Timing: one heap level per cycle on a two-read, one-write entry memory
// with registered reads, compared by a single shared key comparator.
// Insert reads the parent of the new slot and moves larger parents down a
// level at a time before writing the new entry; extract reads the root and
// last entry, then sifts the last entry down, or ends there when it removes
// the last entry. Full inserts and empty extracts answer without raising busy.
// busy stays high from acceptance until the result strobe; a new
// transaction may be taken in the cycle the result is shown.
// Reset clears the entry count; the memory contents need no clearing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_min_heap_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bmh_pkg::in_item_t   in_item,
  output logic                out_valid,
  output bmh_pkg::out_item_t  out_item
);

  bmh_pkg::mem_req_t mem_req;
  bmh_pkg::entry_t   rd_data_a;
  bmh_pkg::entry_t   rd_data_b;

  bmh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .mem_req   (mem_req),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  bmh_store u_store (
    .clk       (clk),
    .req       (mem_req),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for binary_min_heap_queue: a heap predictor inside a
// scoreboard class works out each result when a transaction is accepted,
// and every result strobe is checked field by field against the oldest one.
// Stimulus runs from directed corner cases to random traffic with a fill and
// drain run, under several rates of sender idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  class heap_scoreboard;
    bmh_pkg::key_t       keys [bmh_pkg::CAPACITY];
    bmh_pkg::handle_t    handles [bmh_pkg::CAPACITY];
    int unsigned         count = 0;
    int unsigned         errors = 0;
    bmh_pkg::out_item_t  expected_q [$];

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void swap_entries(int unsigned a, int unsigned b);
      bmh_pkg::key_t    k;
      bmh_pkg::handle_t h;
      k = keys[a];
      h = handles[a];
      keys[a] = keys[b];
      handles[a] = handles[b];
      keys[b] = k;
      handles[b] = h;
    endfunction

    // predict the heap after one accepted transaction and queue its result
    function void note_request(bmh_pkg::in_item_t it);
      bmh_pkg::out_item_t r;
      int unsigned        pos, parent, best, lc, rc;
      bit                 done;
      r = '0;
      r.status = bmh_pkg::STATUS_OK;
      if (it.op == bmh_pkg::OP_INSERT) begin
        if (count >= bmh_pkg::CAPACITY) begin
          r.status = bmh_pkg::STATUS_FULL;
        end else begin
          pos = count;
          keys[pos] = it.key;
          handles[pos] = it.handle;
          done = 1'b0;
          // an equal parent key stops the climb
          while (pos > 0 && !done) begin
            parent = (pos - 1) / 2;
            if (keys[parent] <= keys[pos]) begin
              done = 1'b1;
            end else begin
              swap_entries(parent, pos);
              pos = parent;
            end
          end
          count++;
        end
      end else if (count == 0) begin
        r.status = bmh_pkg::STATUS_EMPTY;
      end else begin
        r.min_key = keys[0];
        r.min_handle = handles[0];
        count--;
        if (count > 0) begin
          keys[0] = keys[count];
          handles[0] = handles[count];
          pos = 0;
          done = 1'b0;
          // strictly smaller child only, left wins a tie
          while (!done) begin
            best = pos;
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc < count && keys[lc] < keys[best]) best = lc;
            if (rc < count && keys[rc] < keys[best]) best = rc;
            if (best == pos) begin
              done = 1'b1;
            end else begin
              swap_entries(pos, best);
              pos = best;
            end
          end
        end
      end
      r.count = bmh_pkg::cnt_t'(count);
      expected_q.push_back(r);
    endfunction

    function void check_result(bmh_pkg::out_item_t got);
      bmh_pkg::out_item_t exp_item;
      string              got_s;
      string              exp_s;
      got_s = $sformatf("status %0d key %h handle %h count %0d",
                        got.status, got.min_key, got.min_handle, got.count);
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with no transaction outstanding: %s", $realtime, got_s);
        return;
      end
      exp_item = expected_q.pop_front();
      if (got.status !== exp_item.status || got.min_key !== exp_item.min_key ||
          got.min_handle !== exp_item.min_handle || got.count !== exp_item.count) begin
        errors++;
        if (errors <= 10) begin
          exp_s = $sformatf("status %0d key %h handle %h count %0d",
                            exp_item.status, exp_item.min_key, exp_item.min_handle,
                            exp_item.count);
          $display("%0t: mismatch: expected %s, got %s", $realtime, exp_s, got_s);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  bmh_pkg::in_item_t  in_item;
  logic               out_valid;
  bmh_pkg::out_item_t out_item;

  heap_scoreboard sb = new();

  binary_min_heap_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // monitor: transaction acceptance and result strobes
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_item);
      if (out_valid) sb.check_result(out_item);
    end
  end

  function automatic bmh_pkg::in_item_t make_item(bmh_pkg::op_t op, bmh_pkg::key_t k,
                                                  bmh_pkg::handle_t h);
    bmh_pkg::in_item_t it;
    it.op = op;
    it.key = k;
    it.handle = h;
    return it;
  endfunction

  // narrow ranges give plenty of equal keys
  function automatic bmh_pkg::key_t rand_key();
    bmh_pkg::key_t k;
    case ($urandom_range(4))
      0: k = bmh_pkg::key_t'($urandom_range(0, 7));
      1: k = bmh_pkg::key_t'($urandom_range(0, 255));
      2: begin
        case ($urandom_range(4))
          0: k = '0;
          1: k = '1;
          2: k = bmh_pkg::key_t'(1);
          3: k = bmh_pkg::key_t'(32'hFFFF_FFFE);
          default: k = bmh_pkg::key_t'(32'h8000_0000);
        endcase
      end
      default: k = bmh_pkg::key_t'($urandom);
    endcase
    return k;
  endfunction

  function automatic bmh_pkg::handle_t rand_handle();
    bmh_pkg::handle_t h;
    case ($urandom_range(9))
      0: h = '0;
      1: h = '1;
      default: h = bmh_pkg::handle_t'($urandom_range(0, 65535));
    endcase
    return h;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(bmh_pkg::in_item_t it, int idle_pct);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    // busy only moves at a rising edge, so its level here decides the next one
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int insert_pct, int idle_pct);
    bmh_pkg::op_t op;
    op = ($urandom_range(99) < insert_pct) ? bmh_pkg::OP_INSERT : bmh_pkg::OP_EXTRACT;
    send_item(make_item(op, rand_key(), rand_handle()), idle_pct);
  endtask

  // sender holds off until every outstanding transaction has answered
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic fill_and_drain(int idle_pct);
    while (sb.count < bmh_pkg::CAPACITY)
      send_item(make_item(bmh_pkg::OP_INSERT, rand_key(), rand_handle()), idle_pct);
    repeat (3) send_item(make_item(bmh_pkg::OP_INSERT, rand_key(), rand_handle()), idle_pct);
    while (sb.count > 0) send_random(15, idle_pct);
    repeat (3) send_item(make_item(bmh_pkg::OP_EXTRACT, rand_key(), rand_handle()), idle_pct);
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty extract, ties, extremes, removal of the last entry
    send_item(make_item(bmh_pkg::OP_EXTRACT, '1, '1), 0);
    send_item(make_item(bmh_pkg::OP_INSERT, bmh_pkg::key_t'(5), bmh_pkg::handle_t'(1)), 0);
    send_item(make_item(bmh_pkg::OP_INSERT, bmh_pkg::key_t'(5), bmh_pkg::handle_t'(2)), 0);
    send_item(make_item(bmh_pkg::OP_INSERT, bmh_pkg::key_t'(5), bmh_pkg::handle_t'(3)), 0);
    send_item(make_item(bmh_pkg::OP_INSERT, '0, '0), 0);
    send_item(make_item(bmh_pkg::OP_INSERT, '1, '1), 0);
    send_item(make_item(bmh_pkg::OP_INSERT, bmh_pkg::key_t'(3),
                        bmh_pkg::handle_t'(16'hAAAA)), 0);
    send_item(make_item(bmh_pkg::OP_INSERT, bmh_pkg::key_t'(5), bmh_pkg::handle_t'(4)), 0);
    send_item(make_item(bmh_pkg::OP_INSERT, bmh_pkg::key_t'(1),
                        bmh_pkg::handle_t'(16'h5555)), 0);
    repeat (8) send_item(make_item(bmh_pkg::OP_EXTRACT, bmh_pkg::key_t'($urandom),
                                   rand_handle()), 0);
    send_item(make_item(bmh_pkg::OP_EXTRACT, '0, '0), 0);
    send_item(make_item(bmh_pkg::OP_INSERT, bmh_pkg::key_t'(32'h8000_0000),
                        bmh_pkg::handle_t'(16'h8000)), 0);
    send_item(make_item(bmh_pkg::OP_EXTRACT, '0, '0), 0);
    send_item(make_item(bmh_pkg::OP_INSERT, bmh_pkg::key_t'(32'h7FFF_FFFF),
                        bmh_pkg::handle_t'(16'h7FFF)), 0);
    send_item(make_item(bmh_pkg::OP_INSERT, '0, '1), 0);
    send_item(make_item(bmh_pkg::OP_EXTRACT, '1, '1), 0);
    send_item(make_item(bmh_pkg::OP_EXTRACT, '1, '1), 0);
    wait_idle();

    // back to back, with a fill to capacity and a full drain
    repeat (150) send_random(70, 0);
    fill_and_drain(0);
    wait_idle();

    // sender idling often
    repeat (300) send_random(55, 58);
    wait_idle();

    // sender idling now and then
    repeat (300) send_random(50, 21);

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bmh_pkg.sv
rtl/core/bmh_store.sv
rtl/core/bmh_cmp.sv
rtl/core/bmh_ctrl.sv
rtl/core/binary_min_heap_queue.sv
tb/tb.sv
